@@ rtl/exlx_pkg.sv @@
// Shared types, codes and character-class functions of the expression lexer.
package exlx_pkg;

    localparam int CP_BITS     = 21;
    localparam int MAX_RESULTS = 5;
    localparam int CNT_BITS    = 3;

    // Lexer scan modes
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_INT   = 4'd1,
        MODE_FRAC  = 4'd2,
        MODE_E     = 4'd3,
        MODE_ESIGN = 4'd4,
        MODE_EXP   = 4'd5,
        MODE_IDENT = 4'd6,
        MODE_DOT   = 4'd7,
        MODE_OP1   = 4'd8
    } lex_mode_t;

    // Token kinds
    localparam logic [2:0] KIND_NUMBER   = 3'd0;
    localparam logic [2:0] KIND_IDENT    = 3'd1;
    localparam logic [2:0] KIND_OPERATOR = 3'd2;
    localparam logic [2:0] KIND_ERROR    = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    // Operator codes
    localparam logic [4:0] OP_MUL       = 5'd0;
    localparam logic [4:0] OP_DIV       = 5'd1;
    localparam logic [4:0] OP_MOD       = 5'd2;
    localparam logic [4:0] OP_PLUS      = 5'd3;
    localparam logic [4:0] OP_MINUS     = 5'd4;
    localparam logic [4:0] OP_POWER     = 5'd5;
    localparam logic [4:0] OP_NEGATE    = 5'd6;
    localparam logic [4:0] OP_GREATER   = 5'd7;
    localparam logic [4:0] OP_LESS      = 5'd8;
    localparam logic [4:0] OP_GE        = 5'd9;
    localparam logic [4:0] OP_LE        = 5'd10;
    localparam logic [4:0] OP_EQ        = 5'd11;
    localparam logic [4:0] OP_NE        = 5'd12;
    localparam logic [4:0] OP_OR        = 5'd13;
    localparam logic [4:0] OP_AND       = 5'd14;
    localparam logic [4:0] OP_TERN_T    = 5'd15;
    localparam logic [4:0] OP_TERN_F    = 5'd16;
    localparam logic [4:0] OP_GRP_S     = 5'd17;
    localparam logic [4:0] OP_GRP_E     = 5'd18;
    localparam logic [4:0] OP_IDX_S     = 5'd19;
    localparam logic [4:0] OP_IDX_E     = 5'd20;
    localparam logic [4:0] OP_COMMA     = 5'd21;
    localparam logic [4:0] OP_DOT       = 5'd22;
    localparam logic [4:0] OP_PRIME     = 5'd23;
    localparam logic [4:0] OP_SEMI      = 5'd24;
    localparam logic [4:0] OP_TRANSPOSE = 5'd25;
    localparam logic [4:0] OP_SQUARE    = 5'd26;

    function automatic logic is_digit(input logic [CP_BITS-1:0] c);
        return (c >= 21'h30) && (c <= 21'h39);
    endfunction

    function automatic logic is_space(input logic [CP_BITS-1:0] c);
        return (c == 21'h20) || ((c >= 21'h09) && (c <= 21'h0D));
    endfunction

    // Letters, underscore, Greek/combining block and math-symbol block
    function automatic logic ident_char(input logic [CP_BITS-1:0] c);
        return ((c >= 21'h41) && (c <= 21'h5A)) || ((c >= 21'h61) && (c <= 21'h7A)) ||
               (c == 21'h5F) || ((c >= 21'h2200) && (c <= 21'h22FF)) ||
               ((c >= 21'h0300) && (c <= 21'h03FF));
    endfunction

    function automatic logic is_opchar(input logic [CP_BITS-1:0] c);
        return c inside {21'h2A, 21'h2D, 21'h2B, 21'h2E, 21'h2F, 21'h25, 21'h21,
                         21'h3C, 21'h3E, 21'h3D, 21'h3F, 21'h3A, 21'h26, 21'h7C,
                         21'h28, 21'h29, 21'h2C, 21'h5B, 21'h5D, 21'h27, 21'h3B,
                         21'h5E, 21'h7E, 21'h1D40, 21'h00B2, 21'h2219};
    endfunction

    // First characters that may open a two-character operator
    function automatic logic may_pair(input logic [CP_BITS-1:0] c);
        return c inside {21'h2A, 21'h3D, 21'h3E, 21'h3C, 21'h7C, 21'h26, 21'h21};
    endfunction

    // {found, code} for a two-character operator
    function automatic logic [5:0] pair_code(input logic [CP_BITS-1:0] f,
                                             input logic [CP_BITS-1:0] n);
        logic [5:0] r;
        r = 6'd0;
        if (f == 21'h2A && n == 21'h2A)      r = {1'b1, OP_POWER};
        else if (f == 21'h3D && n == 21'h3D) r = {1'b1, OP_EQ};
        else if (f == 21'h3E && n == 21'h3D) r = {1'b1, OP_GE};
        else if (f == 21'h3C && n == 21'h3D) r = {1'b1, OP_LE};
        else if (f == 21'h7C && n == 21'h7C) r = {1'b1, OP_OR};
        else if (f == 21'h26 && n == 21'h26) r = {1'b1, OP_AND};
        else if (f == 21'h21 && n == 21'h3D) r = {1'b1, OP_NE};
        return r;
    endfunction

    // {found, code} for a one-character operator
    function automatic logic [5:0] single_code(input logic [CP_BITS-1:0] c);
        logic [5:0] r;
        case (c)
            21'h2A:   r = {1'b1, OP_MUL};
            21'h2F:   r = {1'b1, OP_DIV};
            21'h25:   r = {1'b1, OP_MOD};
            21'h2B:   r = {1'b1, OP_PLUS};
            21'h2D:   r = {1'b1, OP_MINUS};
            21'h5E:   r = {1'b1, OP_POWER};
            21'h21:   r = {1'b1, OP_NEGATE};
            21'h3E:   r = {1'b1, OP_GREATER};
            21'h3C:   r = {1'b1, OP_LESS};
            21'h3F:   r = {1'b1, OP_TERN_T};
            21'h3A:   r = {1'b1, OP_TERN_F};
            21'h28:   r = {1'b1, OP_GRP_S};
            21'h29:   r = {1'b1, OP_GRP_E};
            21'h5B:   r = {1'b1, OP_IDX_S};
            21'h5D:   r = {1'b1, OP_IDX_E};
            21'h2C:   r = {1'b1, OP_COMMA};
            21'h2E:   r = {1'b1, OP_DOT};
            21'h27:   r = {1'b1, OP_PRIME};
            21'h3B:   r = {1'b1, OP_SEMI};
            21'h2219: r = {1'b1, OP_MUL};
            21'h1D40: r = {1'b1, OP_TRANSPOSE};
            21'h00B2: r = {1'b1, OP_SQUARE};
            default:  r = 6'd0;
        endcase
        return r;
    endfunction

    // Precedence table
    function automatic logic [3:0] op_priority(input logic [4:0] code);
        logic [3:0] p;
        case (code) inside
            OP_MUL, OP_DIV, OP_MOD:            p = 4'd7;
            OP_PLUS, OP_MINUS:                 p = 4'd6;
            OP_POWER:                          p = 4'd9;
            OP_NEGATE:                         p = 4'd8;
            [OP_GREATER:OP_LE]:                p = 4'd5;
            OP_EQ, OP_NE:                      p = 4'd4;
            OP_OR:                             p = 4'd2;
            OP_AND:                            p = 4'd3;
            OP_TERN_T, OP_TERN_F:              p = 4'd1;
            [OP_GRP_S:OP_SQUARE]:              p = 4'd10;
            default:                           p = 4'd0;
        endcase
        return p;
    endfunction

    function automatic logic op_left(input logic [4:0] code);
        return !(code inside {OP_POWER, OP_NEGATE, OP_TERN_T, OP_TERN_F}) &&
               (code <= OP_SQUARE);
    endfunction

endpackage

@@ rtl/exlx_core.sv @@
// Lexer state registers and the combinational next-state / token logic.
module exlx_core
    import exlx_pkg::*;
#(
    parameter int POS_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [CP_BITS-1:0]  code_point,
    input  logic                end_of_text,
    output logic [CNT_BITS-1:0] res_count,
    output logic [2:0]          res_kind  [MAX_RESULTS],
    output logic [4:0]          res_code  [MAX_RESULTS],
    output logic [POS_BITS-1:0] res_start [MAX_RESULTS],
    output logic [POS_BITS-1:0] res_len   [MAX_RESULTS]
);

    localparam int NUM_CAND = 6;

    typedef struct packed {
        lex_mode_t            mode;
        logic [CP_BITS-1:0]   h0;
        logic [CP_BITS-1:0]   h1;
        logic [1:0]           hc;
        logic [POS_BITS-1:0]  start;
        logic [POS_BITS-1:0]  rl;
        logic                 halted;
    } lex_state_t;

    typedef struct packed {
        logic                 vld;
        logic [2:0]           kind;
        logic [4:0]           code;
        logic [POS_BITS-1:0]  start;
        logic [POS_BITS-1:0]  len;
    } tok_t;

    typedef struct packed {
        lex_state_t st;
        tok_t       tok;
        logic       refeed;
    } feed_res_t;

    lex_state_t          state_reg, state_next;
    logic [POS_BITS-1:0] tpos_reg, tpos_next;
    tok_t                cand [NUM_CAND];

    function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                    input logic [POS_BITS-1:0] b);
        logic [POS_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
    endfunction

    function automatic tok_t mk_tok(input logic [2:0] kind, input logic [4:0] code,
                                    input logic [POS_BITS-1:0] start,
                                    input logic [POS_BITS-1:0] len);
        tok_t t;
        t.vld   = 1'b1;
        t.kind  = kind;
        t.code  = code;
        t.start = start;
        t.len   = len;
        return t;
    endfunction

    function automatic lex_state_t go_idle(input lex_state_t s);
        lex_state_t r;
        r        = s;
        r.mode   = MODE_IDLE;
        r.h0     = '0;
        r.h1     = '0;
        r.hc     = 2'd0;
        r.start  = '0;
        r.rl     = '0;
        return r;
    endfunction

    function automatic lex_state_t begin_tok(input lex_state_t s, input lex_mode_t m,
                                             input logic [POS_BITS-1:0] pos);
        lex_state_t r;
        r       = s;
        r.mode  = m;
        r.start = pos;
        r.rl    = POS_BITS'(1);
        return r;
    endfunction

    // One character through the scanner; refeed asks for a second pass from idle
    function automatic feed_res_t feed_core(input lex_state_t s,
                                            input logic [CP_BITS-1:0] c,
                                            input logic e,
                                            input logic [POS_BITS-1:0] pos);
        feed_res_t  r;
        logic       dg;
        logic [5:0] pc;
        logic [5:0] sc;
        logic [5:0] hs;
        r.st     = s;
        r.tok    = '0;
        r.refeed = 1'b0;
        dg       = !e && is_digit(c);
        pc       = pair_code(s.h0, c);
        sc       = single_code(c);
        hs       = single_code(s.h0);
        if (!s.halted) begin
            case (s.mode)
                MODE_IDLE:
                begin
                    if (!(e || is_space(c))) begin
                        if (dg) begin
                            r.st = begin_tok(s, MODE_INT, pos);
                        end else if (c == 21'h2E) begin
                            r.st    = begin_tok(s, MODE_DOT, pos);
                            r.st.h0 = c;
                            r.st.hc = 2'd1;
                        end else if (is_opchar(c) && may_pair(c)) begin
                            r.st    = begin_tok(s, MODE_OP1, pos);
                            r.st.h0 = c;
                            r.st.hc = 2'd1;
                        end else if (is_opchar(c) && sc[5]) begin
                            r.tok = mk_tok(KIND_OPERATOR, sc[4:0], pos, POS_BITS'(1));
                        end else if (!is_opchar(c) && ident_char(c)) begin
                            r.st = begin_tok(s, MODE_IDENT, pos);
                        end else begin
                            r.tok       = mk_tok(KIND_ERROR, OP_MUL, pos, POS_BITS'(1));
                            r.st        = go_idle(s);
                            r.st.halted = 1'b1;
                        end
                    end
                end
                MODE_INT, MODE_FRAC:
                begin
                    if (dg) begin
                        r.st.rl = sat_add(s.rl, POS_BITS'(1));
                    end else if (!e && c == 21'h2E && s.mode == MODE_INT) begin
                        r.st.mode = MODE_FRAC;
                        r.st.rl   = sat_add(s.rl, POS_BITS'(1));
                    end else if (!e && (c == 21'h65 || c == 21'h45)) begin
                        r.st.mode = MODE_E;
                        r.st.h0   = c;
                        r.st.hc   = 2'd1;
                    end else begin
                        r.tok    = mk_tok(KIND_NUMBER, OP_MUL, s.start, s.rl);
                        r.st     = go_idle(s);
                        r.refeed = 1'b1;
                    end
                end
                MODE_E:
                begin
                    if (dg) begin
                        r.st.mode = MODE_EXP;
                        r.st.hc   = 2'd0;
                        r.st.rl   = sat_add(s.rl, POS_BITS'(2));
                    end else if (!e && (c == 21'h2B || c == 21'h2D)) begin
                        r.st.mode = MODE_ESIGN;
                        r.st.h1   = c;
                        r.st.hc   = 2'd2;
                    end else begin
                        r.st     = go_idle(s);
                        r.refeed = 1'b1;
                    end
                end
                MODE_ESIGN:
                begin
                    if (dg) begin
                        r.st.mode = MODE_EXP;
                        r.st.hc   = 2'd0;
                        r.st.rl   = sat_add(s.rl, POS_BITS'(3));
                    end else begin
                        r.st     = go_idle(s);
                        r.refeed = 1'b1;
                    end
                end
                MODE_EXP:
                begin
                    if (dg) begin
                        r.st.rl = sat_add(s.rl, POS_BITS'(1));
                    end else begin
                        r.tok    = mk_tok(KIND_NUMBER, OP_MUL, s.start, s.rl);
                        r.st     = go_idle(s);
                        r.refeed = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (!e && (ident_char(c) || is_digit(c))) begin
                        r.st.rl = sat_add(s.rl, POS_BITS'(1));
                    end else begin
                        r.tok    = mk_tok(KIND_IDENT, OP_MUL, s.start, s.rl);
                        r.st     = go_idle(s);
                        r.refeed = 1'b1;
                    end
                end
                MODE_DOT:
                begin
                    if (dg) begin
                        r.st.mode = MODE_FRAC;
                        r.st.hc   = 2'd0;
                        r.st.rl   = sat_add(s.rl, POS_BITS'(1));
                    end else begin
                        r.tok    = mk_tok(KIND_OPERATOR, OP_DOT, s.start, POS_BITS'(1));
                        r.st     = go_idle(s);
                        r.refeed = 1'b1;
                    end
                end
                MODE_OP1:
                begin
                    r.st = go_idle(s);
                    if (!e && pc[5]) begin
                        r.tok = mk_tok(KIND_OPERATOR, pc[4:0], s.start, POS_BITS'(2));
                    end else if (!hs[5]) begin
                        r.tok       = mk_tok(KIND_ERROR, OP_MUL, s.start, POS_BITS'(1));
                        r.st.halted = 1'b1;
                    end else begin
                        r.tok    = mk_tok(KIND_OPERATOR, hs[4:0], s.start, POS_BITS'(1));
                        r.refeed = 1'b1;
                    end
                end
                default:
                begin
                    r.st     = go_idle(s);
                    r.refeed = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    // Next state and candidate tokens, in output order
    always_comb
    begin
        lex_state_t          s0;
        feed_res_t           r1;
        feed_res_t           r2;
        logic                dg;
        logic [CP_BITS-1:0]  ch;
        logic [POS_BITS-1:0] epos;
        logic [POS_BITS-1:0] spos;
        ch   = end_of_text ? '0 : code_point;
        dg   = !end_of_text && is_digit(ch);
        epos = sat_add(state_reg.start, state_reg.rl);
        spos = sat_add(state_reg.start, sat_add(state_reg.rl, POS_BITS'(1)));
        for (int i = 0; i < NUM_CAND; i++) begin
            cand[i] = '0;
        end
        s0 = state_reg;

        // broken exponent: number ends, held e/E (and sign) lexed again
        if (!state_reg.halted && state_reg.mode == MODE_E && !dg &&
            !(!end_of_text && (ch == 21'h2B || ch == 21'h2D))) begin
            cand[0] = mk_tok(KIND_NUMBER, OP_MUL, state_reg.start, state_reg.rl);
            s0      = begin_tok(go_idle(state_reg), MODE_IDENT, epos);
        end else if (!state_reg.halted && state_reg.mode == MODE_ESIGN && !dg) begin
            cand[0] = mk_tok(KIND_NUMBER, OP_MUL, state_reg.start, state_reg.rl);
            cand[1] = mk_tok(KIND_IDENT, OP_MUL, epos, POS_BITS'(1));
            cand[2] = mk_tok(KIND_OPERATOR, (state_reg.h1 == 21'h2B) ? OP_PLUS : OP_MINUS,
                             spos, POS_BITS'(1));
            s0      = go_idle(state_reg);
        end

        r1      = feed_core(s0, ch, end_of_text, tpos_reg);
        r2      = feed_core(r1.st, ch, end_of_text, tpos_reg);
        cand[3] = r1.tok;
        cand[4] = r1.refeed ? r2.tok : '0;
        state_next = r1.refeed ? r2.st : r1.st;

        if (end_of_text) begin
            cand[5]    = mk_tok(KIND_END, OP_MUL, tpos_reg, '0);
            state_next = '0;
            tpos_next  = '0;
        end else begin
            tpos_next  = sat_add(tpos_reg, POS_BITS'(1));
        end
    end

    // Pack valid candidates into the result list
    always_comb
    begin
        logic [CNT_BITS-1:0] n;
        n = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res_kind[i]  = '0;
            res_code[i]  = '0;
            res_start[i] = '0;
            res_len[i]   = '0;
        end
        for (int i = 0; i < NUM_CAND; i++) begin
            if (cand[i].vld && n < CNT_BITS'(MAX_RESULTS)) begin
                res_kind[n]  = cand[i].kind;
                res_code[n]  = cand[i].code;
                res_start[n] = cand[i].start;
                res_len[n]   = cand[i].len;
                n            = n + CNT_BITS'(1);
            end
        end
        res_count = n;
    end

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
            tpos_reg  <= '0;
        end else if (step) begin
            state_reg <= state_next;
            tpos_reg  <= tpos_next;
        end
    end

endmodule

@@ rtl/exlx_outq.sv @@
// Result buffer: holds one request's tokens and hands them out one per cycle while out_stall is low.
module exlx_outq
    import exlx_pkg::*;
#(
    parameter int POS_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [CNT_BITS-1:0] load_count,
    input  logic [2:0]          load_kind  [MAX_RESULTS],
    input  logic [4:0]          load_code  [MAX_RESULTS],
    input  logic [POS_BITS-1:0] load_start [MAX_RESULTS],
    input  logic [POS_BITS-1:0] load_len   [MAX_RESULTS],
    input  logic                out_stall,
    output logic                out_valid,
    output logic                hold_input,
    output logic [2:0]          token_kind,
    output logic [4:0]          operator_code,
    output logic [3:0]          priority_res,
    output logic                assoc_left,
    output logic [POS_BITS-1:0] token_start,
    output logic [POS_BITS-1:0] token_length,
    output logic                last_of_run
);

    logic [2:0]          kind_reg  [MAX_RESULTS];
    logic [4:0]          code_reg  [MAX_RESULTS];
    logic [POS_BITS-1:0] start_reg [MAX_RESULTS];
    logic [POS_BITS-1:0] len_reg   [MAX_RESULTS];
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] rd_reg;
    logic                take;
    logic                at_last;

    // Handshake and drain control
    assign out_valid  = (rd_reg != cnt_reg);
    assign at_last    = (rd_reg + CNT_BITS'(1) == cnt_reg);
    assign take       = out_valid && !out_stall;
    assign hold_input = out_valid && !(take && at_last);

    // Output fields
    always_comb
    begin
        token_kind    = kind_reg[rd_reg];
        operator_code = code_reg[rd_reg];
        token_start   = start_reg[rd_reg];
        token_length  = len_reg[rd_reg];
        last_of_run   = at_last;
        if (kind_reg[rd_reg] == KIND_OPERATOR) begin
            priority_res = op_priority(code_reg[rd_reg]);
            assoc_left   = op_left(code_reg[rd_reg]);
        end else begin
            priority_res = 4'd0;
            assoc_left   = 1'b0;
        end
    end

    // Token payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg  <= load_kind;
            code_reg  <= load_code;
            start_reg <= load_start;
            len_reg   <= load_len;
        end
    end

    // Fill and read pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (load) begin
            cnt_reg <= load_count;
            rd_reg  <= '0;
        end else if (take && at_last) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (take) begin
            rd_reg  <= rd_reg + CNT_BITS'(1);
        end
    end

endmodule

@@ rtl/expression_lexer_top.sv @@
// The first token of a request is offered in the cycle after it is accepted.
// One request per cycle while each gives at most one token and out_stall is low; a
// request giving more tokens holds the input until its last token is taken.
// Reset (rst_n, asynchronous, active low) returns the scanner to idle at offset zero
// and empties the result buffer.
module expression_lexer_top
    import exlx_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CP_BITS-1:0]       code_point,
    input  logic                     end_of_text,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               token_kind,
    output logic [4:0]               operator_code,
    output logic [3:0]               priority_res,
    output logic                     assoc_left,
    output logic [POSITION_BITS-1:0] token_start,
    output logic [POSITION_BITS-1:0] token_length,
    output logic                     last_of_run
);

    logic                     step;
    logic [CNT_BITS-1:0]      res_count;
    logic [2:0]               res_kind  [MAX_RESULTS];
    logic [4:0]               res_code  [MAX_RESULTS];
    logic [POSITION_BITS-1:0] res_start [MAX_RESULTS];
    logic [POSITION_BITS-1:0] res_len   [MAX_RESULTS];

    assign step = in_valid && !in_stall;

    // Scanner
    exlx_core #(.POS_BITS(POSITION_BITS)) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .code_point (code_point),
        .end_of_text(end_of_text),
        .res_count  (res_count),
        .res_kind   (res_kind),
        .res_code   (res_code),
        .res_start  (res_start),
        .res_len    (res_len)
    );

    // Result buffer
    exlx_outq #(.POS_BITS(POSITION_BITS)) u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (step),
        .load_count   (res_count),
        .load_kind    (res_kind),
        .load_code    (res_code),
        .load_start   (res_start),
        .load_len     (res_len),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .hold_input   (in_stall),
        .token_kind   (token_kind),
        .operator_code(operator_code),
        .priority_res (priority_res),
        .assoc_left   (assoc_left),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

`ifndef ASSERT_OFF
    // Input is only held back by tokens still waiting
    a_stall_needs_tokens: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty result buffer");

    // End token closes the run of its request
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_kind == KIND_END) |-> last_of_run)
        else $error("end token not last of run");

    // Non-operators carry no precedence
    a_nonop_prio: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_kind != KIND_OPERATOR) |-> (priority_res == 4'd0 && !assoc_left))
        else $error("precedence on non-operator token");
`endif

endmodule
